### rtl/core/assert_macros.svh
// Assertion helpers shared by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/core/sexts_pkg.sv
// ----------------------------------------------------------------------------
// sexts_pkg
// Token kinds, character classes and the front-to-back record type.
// ----------------------------------------------------------------------------
package sexts_pkg;

  localparam logic [2:0] K_LPAREN = 3'd0;
  localparam logic [2:0] K_RPAREN = 3'd1;
  localparam logic [2:0] K_UNSIGNED = 3'd2;
  localparam logic [2:0] K_SIGNED = 3'd3;
  localparam logic [2:0] K_DECIMAL = 3'd4;
  localparam logic [2:0] K_IDENT = 3'd5;
  localparam logic [2:0] K_STRING = 3'd6;
  localparam logic [2:0] K_ERROR = 3'd7;

  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_LP = 8'h28;
  localparam logic [7:0] CH_RP = 8'h29;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_UNDER = 8'h5f;

  // Byte class computed once in the front stage.
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       is_dig;
    logic       is_id;
    logic       is_ws;
    logic       over;   // byte offset already at the limit
    logic [3:0] digit;
  } sexts_cls_t;

  function automatic logic f_dig(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic f_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h0a) || (c == 8'h0d) || (c == 8'h09);
  endfunction

  function automatic logic f_id(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           f_dig(c) || (c == CH_UNDER) || (c == 8'h2b) || (c == CH_MINUS) ||
           (c == 8'h2f) || (c == 8'h2a) || (c == 8'h3c) || (c == 8'h3e) ||
           (c == 8'h3d) || (c == 8'h5b) || (c == 8'h5d);
  endfunction

endpackage

### rtl/core/sexts_front.sv
// ----------------------------------------------------------------------------
// sexts_front
// Accepts bytes, classifies them and tracks the byte offset.
// ----------------------------------------------------------------------------
module sexts_front import sexts_pkg::*; #(
  parameter int OFFSET_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_ch,
  input  logic                 in_eoi,
  output logic                 q_valid,
  input  logic                 q_ready,
  output sexts_cls_t           q_cls,
  output logic [OFFSET_BITS:0] q_off
);

  localparam logic [OFFSET_BITS:0] LIMIT = {1'b1, {OFFSET_BITS{1'b0}}};

  logic [OFFSET_BITS:0] off_r, off_nxt;
  logic                 acc;

  assign q_valid = in_valid;
  assign in_ready = q_ready;
  assign acc = in_valid && q_ready;

  always_comb begin
    q_cls.ch = in_ch;
    q_cls.eoi = in_eoi;
    q_cls.is_dig = f_dig(in_ch);
    q_cls.is_id = f_id(in_ch);
    q_cls.is_ws = f_ws(in_ch);
    q_cls.over = off_r[OFFSET_BITS];
    q_cls.digit = 4'(in_ch - CH_0);
    q_off = off_r;
  end

  always_comb begin
    off_nxt = off_r;
    if (acc) begin
      if (in_eoi) begin
        off_nxt = '0;
      end else if (off_r < LIMIT) begin
        off_nxt = off_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
    end else begin
      off_r <= off_nxt;
    end
  end

endmodule

### rtl/core/sexts_queue.sv
// ----------------------------------------------------------------------------
// sexts_queue
// Two-entry queue between the classifier and the token engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sexts_queue import sexts_pkg::*; #(
  parameter int OFFSET_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  sexts_cls_t           wr_cls,
  input  logic [OFFSET_BITS:0] wr_off,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output sexts_cls_t           rd_cls,
  output logic [OFFSET_BITS:0] rd_off
);

  sexts_cls_t           cls_mem [2];
  logic [OFFSET_BITS:0] off_mem [2];
  logic                 wp_r, rp_r;
  logic [1:0]           cnt_r;
  logic                 wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_cls = cls_mem[rp_r];
  assign rd_off = off_mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      cls_mem[wp_r] <= wr_cls;
      off_mem[wp_r] <= wr_off;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  `ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= 2'd2)
  `ASSERT_NEXT(a_cnt_inc, clk, rst_n, wr && !rd, cnt_r == $past(cnt_r) + 2'd1)

endmodule

### rtl/core/sexts_back.sv
// ----------------------------------------------------------------------------
// sexts_back
// Token engine: one byte per unstalled cycle, into up to two result records.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sexts_back import sexts_pkg::*; #(
  parameter int OFFSET_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sexts_cls_t             in_cls,
  input  logic [OFFSET_BITS:0]   in_off,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             o_kind,
  output logic [OFFSET_BITS-1:0] o_start,
  output logic [OFFSET_BITS:0]   o_end,
  output logic [31:0]            o_int,
  output logic [63:0]            o_whole,
  output logic [31:0]            o_frac,
  output logic [5:0]             o_fcnt,
  output logic                   o_neg,
  output logic                   o_last
);

  typedef enum logic [6:0] {
    M_IDLE = 7'b0000001, M_MINUS = 7'b0000010, M_INT = 7'b0000100,
    M_FRAC = 7'b0001000, M_IDENT = 7'b0010000, M_STRING = 7'b0100000,
    M_HALT = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [2:0]             kind;
    logic [OFFSET_BITS-1:0] s;
    logic [OFFSET_BITS:0]   e;
    logic [31:0]            iv;
    logic [63:0]            wp;
    logic [31:0]            fd;
    logic [5:0]             fc;
    logic                   neg;
  } rec_t;

  localparam logic [OFFSET_BITS:0] LIMIT = {1'b1, {OFFSET_BITS{1'b0}}};

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] ts_r, ts_nxt;
  logic [63:0]            wh_r, wh_nxt;
  logic [31:0]            fr_r, fr_nxt;
  logic [5:0]             fc_r, fc_nxt;
  logic                   neg_r, neg_nxt;

  // Output buffer: two result slots.
  rec_t rec_r [2];
  rec_t r0, r1;
  logic [1:0] n_r, n;
  logic       sel_r;
  logic       take;

  assign in_ready = (n_r == 2'd0) || ((n_r == 2'd1) && out_ready);
  assign take = in_valid && in_ready;
  assign out_valid = (n_r != 2'd0);

  always_comb begin
    rec_t cur;
    cur = rec_r[sel_r];
    o_kind = cur.kind;
    o_start = cur.s;
    o_end = cur.e;
    o_int = cur.iv;
    o_whole = cur.wp;
    o_frac = cur.fd;
    o_fcnt = cur.fc;
    o_neg = cur.neg;
    o_last = (n_r == 2'd1);
  end

  function automatic rec_t mk(input logic [2:0] k, input logic [OFFSET_BITS-1:0] s,
                              input logic [OFFSET_BITS:0] e);
    rec_t r;
    r = '0;
    r.kind = k;
    r.s = s;
    r.e = e;
    return r;
  endfunction

  always_comb begin
    logic [OFFSET_BITS-1:0] offs;
    logic [OFFSET_BITS:0]   off1;
    logic                   do_close, do_start;
    logic [63:0]            wx;
    logic [31:0]            fx;
    rec_t                   cr;
    offs = in_off[OFFSET_BITS-1:0];
    off1 = in_off + 1'b1;
    do_close = 1'b0;
    do_start = 1'b0;
    wx = (wh_r << 3) + (wh_r << 1) + {60'd0, in_cls.digit};
    fx = (fr_r << 3) + (fr_r << 1) + {28'd0, in_cls.digit};
    mode_nxt = mode_r;
    ts_nxt = ts_r;
    wh_nxt = wh_r;
    fr_nxt = fr_r;
    fc_nxt = fc_r;
    neg_nxt = neg_r;
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    cr = '0;
    if (mode_r != M_HALT && in_cls.over) begin
      r0 = mk(K_ERROR, (mode_r == M_IDLE) ? {OFFSET_BITS{1'b1}} : ts_r, LIMIT);
      n = 2'd1;
      mode_nxt = M_HALT;
      wh_nxt = '0;
      fr_nxt = '0;
      fc_nxt = '0;
      neg_nxt = 1'b0;
    end else begin
      case (mode_r)
        M_IDLE: do_start = 1'b1;
        M_MINUS: begin
          if (in_cls.is_dig) begin
            mode_nxt = M_INT;
            neg_nxt = 1'b1;
            wh_nxt = {60'd0, in_cls.digit};
          end else if (in_cls.is_id) begin
            mode_nxt = M_IDENT;
          end else begin
            do_close = 1'b1;
          end
        end
        M_INT: begin
          if (in_cls.is_dig) wh_nxt = wx;
          else if (in_cls.ch == CH_DOT) mode_nxt = M_FRAC;
          else do_close = 1'b1;
        end
        M_FRAC: begin
          if (in_cls.is_dig) begin
            fr_nxt = fx;
            if (fc_r != 6'd63) fc_nxt = fc_r + 6'd1;
          end else begin
            do_close = 1'b1;
          end
        end
        M_IDENT: if (!in_cls.is_id) do_close = 1'b1;
        M_STRING: begin
          if (in_cls.ch == CH_QUOTE) begin
            r0 = mk(K_STRING, ts_r, off1);
            n = 2'd1;
            mode_nxt = M_IDLE;
          end
        end
        M_HALT: ;
        default: ;
      endcase
      if (do_close) begin
        cr = mk(K_IDENT, ts_r, in_off);
        if (mode_r == M_INT) begin
          cr.kind = neg_r ? K_SIGNED : K_UNSIGNED;
          cr.iv = neg_r ? (32'd0 - wh_r[31:0]) : wh_r[31:0];
        end else if (mode_r == M_FRAC) begin
          cr.kind = K_DECIMAL;
          cr.wp = wh_r;
          cr.fd = fr_r;
          cr.fc = fc_r;
          cr.neg = neg_r;
        end
        r0 = cr;
        n = 2'd1;
        mode_nxt = M_IDLE;
        wh_nxt = '0;
        fr_nxt = '0;
        fc_nxt = '0;
        neg_nxt = 1'b0;
        do_start = 1'b1;
      end
      if (do_start) begin
        ts_nxt = offs;
        if (!in_cls.is_ws) begin
          cr = mk(K_ERROR, offs, off1);
          if (in_cls.ch == CH_LP) cr.kind = K_LPAREN;
          else if (in_cls.ch == CH_RP) cr.kind = K_RPAREN;
          if (in_cls.ch == CH_LP || in_cls.ch == CH_RP || !(in_cls.ch == CH_MINUS ||
              in_cls.is_id || in_cls.ch == CH_QUOTE)) begin
            if (n == 2'd0) r0 = cr;
            else r1 = cr;
            n = n + 2'd1;
            if (cr.kind == K_ERROR) mode_nxt = M_HALT;
          end else if (in_cls.ch == CH_MINUS) begin
            mode_nxt = M_MINUS;
          end else if (in_cls.is_dig) begin
            mode_nxt = M_INT;
            wh_nxt = {60'd0, in_cls.digit};
            neg_nxt = 1'b0;
          end else if (in_cls.is_id) begin
            mode_nxt = M_IDENT;
          end else begin
            mode_nxt = M_STRING;
          end
        end
      end
    end
    if (in_cls.eoi) begin
      if (mode_nxt != M_IDLE && mode_nxt != M_HALT) begin
        cr = mk(K_IDENT, ts_nxt, off1);
        if (mode_nxt == M_INT) begin
          cr.kind = neg_nxt ? K_SIGNED : K_UNSIGNED;
          cr.iv = neg_nxt ? (32'd0 - wh_nxt[31:0]) : wh_nxt[31:0];
        end else if (mode_nxt == M_FRAC) begin
          cr.kind = K_DECIMAL;
          cr.wp = wh_nxt;
          cr.fd = fr_nxt;
          cr.fc = fc_nxt;
          cr.neg = neg_nxt;
        end else if (mode_nxt == M_STRING) begin
          cr.kind = K_ERROR;
        end
        if (n == 2'd0) r0 = cr;
        else r1 = cr;
        n = n + 2'd1;
      end
      mode_nxt = M_IDLE;
      ts_nxt = '0;
      wh_nxt = '0;
      fr_nxt = '0;
      fc_nxt = '0;
      neg_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rec_r[0] <= r0;
      rec_r[1] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= '0;
      wh_r <= '0;
      fr_r <= '0;
      fc_r <= '0;
      neg_r <= 1'b0;
    end else if (take) begin
      ts_r <= ts_nxt;
      wh_r <= wh_nxt;
      fr_r <= fr_nxt;
      fc_r <= fc_nxt;
      neg_r <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      n_r <= 2'd0;
      sel_r <= 1'b0;
    end else if (take) begin
      mode_r <= mode_nxt;
      n_r <= n;
      sel_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      n_r <= n_r - 2'd1;
      sel_r <= 1'b1;
    end
  end

  `ASSERT_IMPL(a_onehot, clk, rst_n, 1'b1, $onehot(mode_r))
  `ASSERT_IMPL(a_n_max, clk, rst_n, 1'b1, n_r <= 2'd2)
  `ASSERT_NEXT(a_halt_stays, clk, rst_n, mode_r == M_HALT && !(take && in_cls.eoi),
               mode_r == M_HALT)

endmodule

### rtl/core/sexpr_token_scanner_unit.sv
// ----------------------------------------------------------------------------
// sexpr_token_scanner_unit
// Byte-stream S-expression tokenizer with byte spans.
// ----------------------------------------------------------------------------
// Usage:
//   Input: one source byte per beat on s_axis_tdata, s_axis_tlast on the
//   final byte of a text. Output: one token per beat on m_axis_tdata; the
//   m_axis_tlast bit marks the last token caused by an input byte.
//   Each byte is classified in the front stage, passes a two-entry queue
//   and is scanned by the token engine, which registers up to two tokens.
//   Throughput: one byte per cycle while each byte yields at most one token
//   and the receiver is ready; a byte that yields two tokens holds the engine
//   until the first leaves the single output port of the two-slot result buffer.
//   A closing byte is held in the queue; its token is then registered in the result buffer.
//   Reset clears offset and scan state; after tlast all state returns there.
//   When the receiver stalls, tokens hold, the queue fills and then
//   s_axis_tready drops; no beat is lost.
// ----------------------------------------------------------------------------
module sexpr_token_scanner_unit import sexts_pkg::*; #(
  parameter int OFFSET_BITS = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // char_byte
  input  logic         s_axis_tlast,  // end_of_input
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // kind, span_start, span_end, int_value, whole_part, frac_digits,
  // frac_count, is_negative (from bit 0 up), zero padded to bytes
  output logic [((3 + OFFSET_BITS + OFFSET_BITS + 1 + 32 + 64 + 32 + 6 + 1 + 7) / 8) * 8 - 1:0]
                       m_axis_tdata,
  output logic         m_axis_tlast   // last_of_item
);

  localparam int DW = 3 + OFFSET_BITS + OFFSET_BITS + 1 + 32 + 64 + 32 + 6 + 1;
  localparam int TW = ((DW + 7) / 8) * 8;

  sexts_cls_t           f_cls, b_cls;
  logic [OFFSET_BITS:0] f_off, b_off;
  logic                 f_valid, f_ready, b_valid, b_ready;
  logic [2:0]             kind;
  logic [OFFSET_BITS-1:0] st;
  logic [OFFSET_BITS:0]   en;
  logic [31:0]            iv, fd;
  logic [63:0]            wp;
  logic [5:0]             fc;
  logic                   ng;

  sexts_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk, .rst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_ch(s_axis_tdata), .in_eoi(s_axis_tlast),
    .q_valid(f_valid), .q_ready(f_ready), .q_cls(f_cls), .q_off(f_off)
  );

  sexts_queue #(.OFFSET_BITS(OFFSET_BITS)) u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_cls(f_cls),
    .wr_off(f_off), .rd_valid(b_valid), .rd_ready(b_ready), .rd_cls(b_cls),
    .rd_off(b_off)
  );

  sexts_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk, .rst_n, .in_valid(b_valid), .in_ready(b_ready), .in_cls(b_cls),
    .in_off(b_off), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .o_kind(kind), .o_start(st), .o_end(en), .o_int(iv), .o_whole(wp),
    .o_frac(fd), .o_fcnt(fc), .o_neg(ng), .o_last(m_axis_tlast)
  );

  // Pack fields from bit 0 upward.
  assign m_axis_tdata = TW'({ng, fc, fd, wp, iv, en, st, kind});

endmodule

### dv/sexpr_token_checker.sv
// ----------------------------------------------------------------------------
// sexpr_token_checker
// Watches the byte and token streams of the scanner, predicts each token
// from the accepted bytes and compares it field by field with the output.
// ----------------------------------------------------------------------------
module sexpr_token_checker import sexts_pkg::*; #(
  parameter int OFFSET_BITS = 20,
  parameter int DW = 184
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s_axis_tvalid,
  input  logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,
  input  logic          s_axis_tlast,
  input  logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic [DW-1:0] m_axis_tdata,
  input  logic          m_axis_tlast,
  output int            fail_count,
  output int            tokens_pending
);

  localparam logic [OFFSET_BITS:0] SPAN_LIMIT = {1'b1, {OFFSET_BITS{1'b0}}};

  // Field positions inside tdata, from bit 0 up.
  localparam int P_END = 3 + OFFSET_BITS;
  localparam int P_INT = P_END + OFFSET_BITS + 1;
  localparam int P_WHOLE = P_INT + 32;
  localparam int P_FRAC = P_WHOLE + 64;
  localparam int P_FCNT = P_FRAC + 32;
  localparam int P_NEG = P_FCNT + 6;

  typedef enum logic [2:0] {
    SC_IDLE, SC_MINUS, SC_INT, SC_FRAC, SC_IDENT, SC_STRING, SC_HALT
  } scan_state_e;

  typedef struct packed {
    logic [2:0]             kind;
    logic [OFFSET_BITS-1:0] span_start;
    logic [OFFSET_BITS:0]   span_end;
    logic [31:0]            int_value;
    logic [63:0]            whole_part;
    logic [31:0]            frac_digits;
    logic [5:0]             frac_count;
    logic                   is_negative;
    logic                   last_of_item;
  } token_t;

  token_t                 token_q[$];
  int                     step_tokens;
  scan_state_e            sc_state;
  logic [OFFSET_BITS:0]   sc_offset;
  logic [OFFSET_BITS-1:0] sc_start;
  logic [63:0]            sc_whole;
  logic [31:0]            sc_frac;
  logic [5:0]             sc_fcount;
  logic                   sc_minus;

  assign tokens_pending = token_q.size();

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || c == 8'h0a || c == 8'h0d || c == 8'h09;
  endfunction

  function automatic logic is_name_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || is_digit(c) ||
           c == CH_UNDER || c == "+" || c == CH_MINUS || c == "/" || c == "*" ||
           c == "<" || c == ">" || c == "=" || c == "[" || c == "]";
  endfunction

  task automatic add_token(logic [2:0] k, logic [OFFSET_BITS:0] s, logic [OFFSET_BITS:0] e,
                           logic [31:0] iv, logic [63:0] wp, logic [31:0] fd,
                           logic [5:0] fc, logic ng);
    token_t t;
    t = '{k, s[OFFSET_BITS-1:0], e, iv, wp, fd, fc, ng, 1'b0};
    token_q.push_back(t);
    step_tokens++;
  endtask

  task automatic clear_open();
    sc_state = SC_IDLE;
    sc_whole = '0;
    sc_frac = '0;
    sc_fcount = '0;
    sc_minus = 1'b0;
  endtask

  // Close whatever token is open, ending it at the given offset.
  task automatic close_open(logic [OFFSET_BITS:0] e);
    logic [31:0] low;
    low = sc_whole[31:0];
    case (sc_state)
      SC_MINUS, SC_IDENT: add_token(K_IDENT, {1'b0, sc_start}, e, '0, '0, '0, '0, 1'b0);
      SC_INT: begin
        if (sc_minus) add_token(K_SIGNED, {1'b0, sc_start}, e, -low, '0, '0, '0, 1'b0);
        else add_token(K_UNSIGNED, {1'b0, sc_start}, e, low, '0, '0, '0, 1'b0);
      end
      SC_FRAC: add_token(K_DECIMAL, {1'b0, sc_start}, e, '0, sc_whole, sc_frac, sc_fcount,
                         sc_minus);
      SC_STRING: add_token(K_ERROR, {1'b0, sc_start}, e, '0, '0, '0, '0, 1'b0);
      default: ;
    endcase
    clear_open();
  endtask

  task automatic begin_token(logic [7:0] c, logic [OFFSET_BITS:0] off);
    sc_start = off[OFFSET_BITS-1:0];
    if (is_space(c)) return;
    if (c == CH_LP) add_token(K_LPAREN, off, off + 1'b1, '0, '0, '0, '0, 1'b0);
    else if (c == CH_RP) add_token(K_RPAREN, off, off + 1'b1, '0, '0, '0, '0, 1'b0);
    else if (c == CH_MINUS) sc_state = SC_MINUS;
    else if (is_digit(c)) begin
      sc_state = SC_INT;
      sc_whole = 64'(c - CH_0);
      sc_minus = 1'b0;
    end else if (is_name_char(c)) sc_state = SC_IDENT;
    else if (c == CH_QUOTE) sc_state = SC_STRING;
    else begin
      add_token(K_ERROR, off, off + 1'b1, '0, '0, '0, '0, 1'b0);
      sc_state = SC_HALT;
    end
  endtask

  task automatic reset_scan();
    clear_open();
    sc_offset = '0;
    sc_start = '0;
  endtask

  task automatic scan_byte(logic [7:0] c, logic eoi);
    logic [OFFSET_BITS:0] off;
    off = sc_offset;
    step_tokens = 0;
    if (sc_state != SC_HALT && off >= SPAN_LIMIT) begin
      add_token(K_ERROR, (sc_state == SC_IDLE) ? SPAN_LIMIT - 1'b1 : {1'b0, sc_start},
                SPAN_LIMIT, '0, '0, '0, '0, 1'b0);
      clear_open();
      sc_state = SC_HALT;
    end else begin
      case (sc_state)
        SC_IDLE: begin_token(c, off);
        SC_MINUS: begin
          if (is_digit(c)) begin
            sc_state = SC_INT;
            sc_minus = 1'b1;
            sc_whole = 64'(c - CH_0);
          end else if (is_name_char(c)) sc_state = SC_IDENT;
          else begin
            close_open(off);
            begin_token(c, off);
          end
        end
        SC_INT: begin
          if (is_digit(c)) sc_whole = sc_whole * 64'd10 + 64'(c - CH_0);
          else if (c == CH_DOT) sc_state = SC_FRAC;
          else begin
            close_open(off);
            begin_token(c, off);
          end
        end
        SC_FRAC: begin
          if (is_digit(c)) begin
            sc_frac = sc_frac * 32'd10 + 32'(c - CH_0);
            if (sc_fcount < 6'd63) sc_fcount++;
          end else begin
            close_open(off);
            begin_token(c, off);
          end
        end
        SC_IDENT: begin
          if (!is_name_char(c)) begin
            close_open(off);
            begin_token(c, off);
          end
        end
        SC_STRING: begin
          if (c == CH_QUOTE) begin
            add_token(K_STRING, {1'b0, sc_start}, off + 1'b1, '0, '0, '0, '0, 1'b0);
            clear_open();
          end
        end
        default: ;
      endcase
    end
    if (sc_offset < SPAN_LIMIT) sc_offset++;
    if (eoi) begin
      if (sc_state != SC_IDLE && sc_state != SC_HALT) close_open(off + 1'b1);
      reset_scan();
    end
    if (step_tokens > 0) token_q[token_q.size()-1].last_of_item = 1'b1;
  endtask

  always @(posedge clk) begin
    token_t got, want;
    if (!rst_n) begin
      reset_scan();
      token_q.delete();
      fail_count <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) scan_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[2:0], m_axis_tdata[3 +: OFFSET_BITS],
               m_axis_tdata[P_END +: OFFSET_BITS + 1], m_axis_tdata[P_INT +: 32],
               m_axis_tdata[P_WHOLE +: 64], m_axis_tdata[P_FRAC +: 32],
               m_axis_tdata[P_FCNT +: 6], m_axis_tdata[P_NEG], m_axis_tlast};
        if (token_q.size() == 0) begin
          $display("%0t: unexpected token %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = token_q.pop_front();
          if (got !== want) begin
            $display("%0t: token mismatch expected %h actual %h", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives source text into the S-expression scanner: a directed set of
// corner texts and random token streams under four idling mixes. The
// checker predicts every token.
// ----------------------------------------------------------------------------
module tb import sexts_pkg::*; ;

  localparam int OB = 20;
  localparam int DW = 184;
  localparam int STALL_LIMIT = 5000;

  logic          clk;
  logic          rst_n;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [7:0]    s_axis_tdata;
  logic          s_axis_tlast;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [DW-1:0] m_axis_tdata;
  logic          m_axis_tlast;
  int            fail_count;
  int            tokens_pending;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            quiet_cycles;
  logic [7:0]    text_q[$];

  sexpr_token_scanner_unit #(.OFFSET_BITS(OB)) dut (.*);

  sexpr_token_checker #(.OFFSET_BITS(OB), .DW(DW)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: stall at the current rate.
  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog: end the run once nothing moves for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drive one beat; sample ready at the falling edge so the accepting
  // rising edge is known without racing the block.
  task automatic put_byte(logic [7:0] b, logic last);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Send the assembled text, tlast on its final byte.
  task automatic send_text();
    foreach (text_q[i]) put_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic add_digits(int n);
    repeat (n) text_q.push_back(8'(8'h30 + $urandom_range(9)));
  endtask

  task automatic add_space();
    logic [7:0] sp[4] = '{8'h20, 8'h0a, 8'h0d, 8'h09};
    repeat ($urandom_range(1, 2)) text_q.push_back(sp[$urandom_range(3)]);
  endtask

  // Append one random token; mostly well formed, now and then a broken one.
  task automatic add_token();
    string name_set;
    name_set = "abzAZ_+-/*<>=[]09q";
    case ($urandom_range(19))
      0, 1: add_str("(");
      2, 3: add_str(")");
      4, 5: add_digits($urandom_range(1, ($urandom_range(7) == 0) ? 25 : 6));
      6: begin add_str("-"); add_digits($urandom_range(1, 12)); end
      7, 8: begin
        if ($urandom_range(1)) add_str("-");
        add_digits($urandom_range(1, 22));
        add_str(".");
        add_digits(($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 6));
      end
      9, 10, 11: begin
        text_q.push_back(name_set[$urandom_range(14)]);
        repeat ($urandom_range(0, 5)) text_q.push_back(name_set[$urandom_range(17)]);
      end
      12, 13: begin
        add_str("\"");
        repeat ($urandom_range(0, 6)) begin
          logic [7:0] b;
          b = 8'($urandom_range(255));
          text_q.push_back(b == CH_QUOTE ? 8'h41 : b);
        end
        if ($urandom_range(5) != 0) add_str("\"");
      end
      14: add_str("-");
      15: add_str(".");
      16: text_q.push_back(8'($urandom_range(255)));
      default: add_space();
    endcase
    if ($urandom_range(2) == 0) add_space();
  endtask

  task automatic random_texts(int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      repeat ($urandom_range(1, 10)) add_token();
      sent += text_q.size();
      send_text();
    end
  endtask

  // Drop valid, then wait for every predicted token to leave.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (tokens_pending == 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    string directed[$];
    rst_n = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner texts: wraps, lone minus, dangling dot, open string, bad bytes.
    directed = '{"(x)", "0 4294967295 4294967296", "-1 -0", "-", "-a-", "12.",
                 "12.5)", ".", "\"ab\"(", "\"open", "18446744073709551616.99",
                 "1.4294967296", "12.x", "(-)", "9 ."};
    foreach (directed[i]) begin
      add_str(directed[i]);
      send_text();
    end
    text_q.push_back(8'hff);
    text_q.push_back(8'h28);
    send_text();
    add_str("a");
    text_q.push_back(8'h00);
    send_text();
    add_str("  ");
    send_text();
    drain();

    send_idle_pct = 0;  recv_stall_pct = 0;  random_texts(290); drain();
    send_idle_pct = 65; recv_stall_pct = 0;  random_texts(290); drain();
    send_idle_pct = 0;  recv_stall_pct = 65; random_texts(290); drain();
    send_idle_pct = 33; recv_stall_pct = 33; random_texts(290); drain();

    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
